// ----- rtl/ens_pkg.sv -----
// shared constants, codes and types of the excitable network step unit
package ens_pkg;

  localparam int unsigned NEURONS   = 2048;
  localparam int unsigned MAX_LINKS = 65536;

  localparam int unsigned NEUR_AW = $clog2(NEURONS);
  localparam int unsigned LINK_AW = $clog2(MAX_LINKS);
  localparam int unsigned LCNT_W  = $clog2(MAX_LINKS + 1);

  localparam int unsigned IDX_W  = 11;
  localparam int unsigned LIFE_W = 4;
  localparam int unsigned ACC_W  = 20;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned PROB_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned LINK_W = 2 * IDX_W + 1 + LIFE_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_EXCIT_DUR   = 3'd1,
    CFG_INHIB_DUR   = 3'd2,
    CFG_EXCIT_W     = 3'd3,
    CFG_INHIB_W     = 3'd4,
    CFG_TARGET_SIZE = 3'd5,
    CFG_PROB_TARGET = 3'd6,
    CFG_PROB_OTHER  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_EXTERNAL = 2'd1,
    CAUSE_SYNAPTIC = 2'd2
  } cause_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LRD,
    S_LFIRE,
    S_LUPD,
    S_DRD,
    S_DDEC
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]  src;
    logic [IDX_W-1:0]  tgt;
    logic              inhib;
    logic [LIFE_W-1:0] life;
  } link_t;

endpackage

// ----- rtl/ens_ram.sv -----
// generic single-port ram with registered read
module ens_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ens_unit.sv -----
// shared arithmetic: lifetime update, saturating accumulate, threshold compare
module ens_unit (
  input  logic [ens_pkg::LIFE_W-1:0] life_i,
  input  logic                       src_firing_i,
  input  logic                       inhib_i,
  input  logic [ens_pkg::LIFE_W-1:0] excit_dur_i,
  input  logic [ens_pkg::LIFE_W-1:0] inhib_dur_i,
  input  logic [6:0]                 excit_weight_i,
  input  logic signed [7:0]          inhib_weight_i,
  input  logic signed [ens_pkg::ACC_W-1:0] acc_i,
  input  logic [7:0]                 threshold_i,
  output logic [ens_pkg::LIFE_W-1:0] life_o,
  output logic signed [ens_pkg::ACC_W-1:0] acc_o,
  output logic                       over_thr_o
);
  import ens_pkg::*;

  logic signed [ACC_W:0] weight;
  logic signed [ACC_W:0] sum;

  always_comb begin
    if (life_i != '0) begin
      life_o = life_i - LIFE_W'(1);
    end else if (src_firing_i) begin
      life_o = inhib_i ? inhib_dur_i : excit_dur_i;
    end else begin
      life_o = '0;
    end
  end

  always_comb begin
    weight = inhib_i ? (ACC_W+1)'(inhib_weight_i)
                     : $signed({{(ACC_W-6){1'b0}}, excit_weight_i});
    sum = $signed({acc_i[ACC_W-1], acc_i}) + weight;
    // top two bits differ when the sum left the 20-bit range
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_o = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_o = sum[ACC_W-1:0];
    end
  end

  assign over_thr_o = acc_i > $signed({{(ACC_W-8){1'b0}}, threshold_i});

endmodule

// ----- rtl/excitable_network_step_unit.sv -----
// top level of the excitable network step unit: sequencer, stores and result register
//
// Input channel (in_valid_i/in_ready_o) takes one word at a time. A word with
// kind_i low appends a link to the table if the table is not yet full. A word with
// kind_i high is a draw for the neuron under the cursor and yields one result
// word on the output channel (out_valid_o/out_ready_i).
// A draw for a neuron other than 0 reads the stores in S_DRD and decides in
// S_DDEC, which fills the result register; the next word can be taken once the
// sequencer is back in S_IDLE. The draw for neuron 0 first clears the accumulator
// memory and then walks the link table, in the steps S_LRD, S_LFIRE and S_LUPD
// per loaded link, through the shared arithmetic unit and the single port of each
// store; it then reads and decides like any other draw.
// in_ready_o is high only while the sequencer is idle.
// After reset the firing and accumulator memories are cleared in one pass over
// all NEURONS addresses, during which no word is accepted; configuration writes are
// taken at any time over cfg_we_i/cfg_index_i/cfg_data_i.
// The result sits in an output register; while the receiver stalls the next
// word is still taken, and a draw then waits at its decision cycle until the
// result register is free.
module excitable_network_step_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [ens_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [ens_pkg::IDX_W-1:0]   link_source_i,
  input  logic [ens_pkg::IDX_W-1:0]   link_target_i,
  input  logic                        link_inhibitory_i,
  input  logic [ens_pkg::PROB_W-1:0]  random_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ens_pkg::IDX_W-1:0]   neuron_index_o,
  output logic                        active_o,
  output logic [1:0]                  cause_o,
  output logic                        end_of_step_o,
  output logic [ens_pkg::CNT_W-1:0]   target_external_count_o,
  output logic [ens_pkg::CNT_W-1:0]   target_synaptic_count_o,
  output logic [ens_pkg::CNT_W-1:0]   other_external_count_o,
  output logic [ens_pkg::CNT_W-1:0]   other_synaptic_count_o
);
  import ens_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [7:0]        thr_q;
  logic [LIFE_W-1:0] exc_dur_q, inh_dur_q;
  logic [6:0]        exc_w_q;
  logic signed [7:0] inh_w_q;
  logic [11:0]       tsize_q;
  logic [PROB_W-1:0] prob_t_q, prob_o_q;

  logic [LCNT_W-1:0]  links_q, links_d;
  logic [LCNT_W-1:0]  lidx_q, lidx_d;
  logic [NEUR_AW-1:0] clr_idx_q, clr_idx_d;
  logic               clr_fire_q, clr_fire_d;
  logic [NEUR_AW-1:0] cursor_q, cursor_d;
  logic [PROB_W-1:0]  rand_q, rand_d;
  logic [CNT_W-1:0]   cnt_q [4];
  logic [CNT_W-1:0]   cnt_d [4];

  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   o_idx_q;
  logic               o_active_q, o_eos_q;
  cause_e             o_cause_q;
  logic [CNT_W-1:0]   o_cnt_q [4];

  // stores
  logic               link_we, fire_we, acc_we;
  logic [LINK_AW-1:0] link_addr;
  logic [NEUR_AW-1:0] fire_addr, acc_addr;
  link_t              link_wdata, link_rdata;
  logic               fire_wdata, fire_rdata;
  logic [ACC_W-1:0]   acc_wdata, acc_rdata;

  logic [LIFE_W-1:0]       new_life;
  logic signed [ACC_W-1:0] acc_sum;
  logic                    over_thr;

  logic accept, load_ok, target_mod, out_free, step_start;
  logic [1:0] slot;
  cause_e cause;

  assign accept   = in_valid_i && in_ready_o;
  assign load_ok  = (32'(links_q) < MAX_LINKS) && (32'(link_source_i) < NEURONS) &&
                    (32'(link_target_i) < NEURONS);
  assign target_mod = 32'(cursor_q) < 32'(tsize_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign step_start = accept && kind_i && (cursor_q == '0);

  ens_ram #(.WIDTH(LINK_W), .DEPTH(MAX_LINKS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  ens_ram #(.WIDTH(1), .DEPTH(NEURONS)) u_fire_ram (
    .clk_i   (clk_i),
    .we_i    (fire_we),
    .addr_i  (fire_addr),
    .wdata_i (fire_wdata),
    .rdata_o (fire_rdata)
  );

  ens_ram #(.WIDTH(ACC_W), .DEPTH(NEURONS)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .addr_i  (acc_addr),
    .wdata_i (acc_wdata),
    .rdata_o (acc_rdata)
  );

  ens_unit u_unit (
    .life_i         (link_rdata.life),
    .src_firing_i   (fire_rdata),
    .inhib_i        (link_rdata.inhib),
    .excit_dur_i    (exc_dur_q),
    .inhib_dur_i    (inh_dur_q),
    .excit_weight_i (exc_w_q),
    .inhib_weight_i (inh_w_q),
    .acc_i          ($signed(acc_rdata)),
    .threshold_i    (thr_q),
    .life_o         (new_life),
    .acc_o          (acc_sum),
    .over_thr_o     (over_thr)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (clr_idx_q == NEUR_AW'(NEURONS - 1)) begin
          state_d = clr_fire_q ? S_IDLE : S_LRD;
        end
      end
      S_IDLE: begin
        if (accept && kind_i) begin
          state_d = (cursor_q == '0) ? S_CLR : S_DRD;
        end
      end
      S_LRD:   state_d = (lidx_q == links_q) ? S_DRD : S_LFIRE;
      S_LFIRE: state_d = S_LUPD;
      S_LUPD:  state_d = S_LRD;
      S_DRD:   state_d = S_DDEC;
      S_DDEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // store control and datapath
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    link_we    = 1'b0;
    fire_we    = 1'b0;
    acc_we     = 1'b0;
    link_addr  = lidx_q[LINK_AW-1:0];
    fire_addr  = cursor_q;
    acc_addr   = cursor_q;
    link_wdata = link_rdata;
    fire_wdata = 1'b0;
    acc_wdata  = acc_sum;
    cause      = CAUSE_NONE;
    links_d    = links_q;
    lidx_d     = lidx_q;
    clr_idx_d  = clr_idx_q;
    clr_fire_d = clr_fire_q;
    cursor_d   = cursor_q;
    rand_d     = rand_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_d      = cnt_q;
    slot       = 2'd0;

    case (state_q)
      S_CLR: begin
        fire_we   = clr_fire_q;
        acc_we    = 1'b1;
        acc_wdata = '0;
        fire_addr = clr_idx_q;
        acc_addr  = clr_idx_q;
        clr_idx_d = clr_idx_q + NEUR_AW'(1);
        if (clr_idx_q == NEUR_AW'(NEURONS - 1)) begin
          clr_idx_d  = '0;
          clr_fire_d = 1'b0;
        end
      end
      S_IDLE: begin
        link_addr  = links_q[LINK_AW-1:0];
        link_wdata = '{src: link_source_i, tgt: link_target_i,
                       inhib: link_inhibitory_i, life: '0};
        if (accept && !kind_i && load_ok) begin
          link_we = 1'b1;
          links_d = links_q + LCNT_W'(1);
        end
        if (accept && kind_i) begin
          rand_d = random_value_i;
          lidx_d = '0;
        end
        if (step_start) begin
          for (int j = 0; j < 4; j++) begin
            cnt_d[j] = '0;
          end
        end
      end
      S_LFIRE: begin
        fire_addr = NEUR_AW'(link_rdata.src);
        acc_addr  = NEUR_AW'(link_rdata.tgt);
      end
      S_LUPD: begin
        acc_addr        = NEUR_AW'(link_rdata.tgt);
        link_we         = 1'b1;
        link_wdata.life = new_life;
        acc_we          = (new_life != '0);
        lidx_d          = lidx_q + LCNT_W'(1);
      end
      S_DDEC: begin
        if (over_thr) begin
          cause = CAUSE_SYNAPTIC;
        end else if (rand_q < (target_mod ? prob_t_q : prob_o_q)) begin
          cause = CAUSE_EXTERNAL;
        end
        slot = {!target_mod, cause == CAUSE_SYNAPTIC};
        if (out_free) begin
          fire_we     = 1'b1;
          fire_wdata  = (cause != CAUSE_NONE);
          out_valid_d = 1'b1;
          if (cause != CAUSE_NONE && cnt_q[slot] != CNT_MAX) begin
            cnt_d[slot] = cnt_q[slot] + CNT_W'(1);
          end
          cursor_d = (cursor_q == NEUR_AW'(NEURONS - 1)) ? '0 : cursor_q + NEUR_AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      links_q     <= '0;
      lidx_q      <= '0;
      clr_idx_q   <= '0;
      clr_fire_q  <= 1'b1;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        cnt_q[j] <= '0;
      end
      thr_q    <= 8'd5;
      exc_dur_q <= 4'd5;
      inh_dur_q <= 4'd7;
      exc_w_q  <= 7'd1;
      inh_w_q  <= -8'sd4;
      tsize_q  <= 12'd256;
      prob_t_q <= 16'd105;
      prob_o_q <= 16'd60;
    end else begin
      state_q     <= state_d;
      links_q     <= links_d;
      lidx_q      <= lidx_d;
      clr_idx_q   <= clr_idx_d;
      clr_fire_q  <= clr_fire_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_THRESHOLD:   thr_q     <= cfg_data_i[7:0];
          CFG_EXCIT_DUR:   exc_dur_q <= cfg_data_i[LIFE_W-1:0];
          CFG_INHIB_DUR:   inh_dur_q <= cfg_data_i[LIFE_W-1:0];
          CFG_EXCIT_W:     exc_w_q   <= cfg_data_i[6:0];
          CFG_INHIB_W:     inh_w_q   <= $signed(cfg_data_i[7:0]);
          CFG_TARGET_SIZE: tsize_q   <= cfg_data_i[11:0];
          CFG_PROB_TARGET: prob_t_q  <= cfg_data_i;
          CFG_PROB_OTHER:  prob_o_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rand_q <= rand_d;
    if (state_q == S_DDEC && out_free) begin
      o_idx_q    <= IDX_W'(cursor_q);
      o_active_q <= (cause != CAUSE_NONE);
      o_cause_q  <= cause;
      o_eos_q    <= (cursor_q == NEUR_AW'(NEURONS - 1));
      o_cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign neuron_index_o          = o_idx_q;
  assign active_o                = o_active_q;
  assign cause_o                 = o_cause_q;
  assign end_of_step_o           = o_eos_q;
  assign target_external_count_o = o_cnt_q[0];
  assign target_synaptic_count_o = o_cnt_q[1];
  assign other_external_count_o  = o_cnt_q[2];
  assign other_synaptic_count_o  = o_cnt_q[3];

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LUPD) |-> (lidx_q < links_q))
    else $error("link walk beyond loaded links");

  a_result_from_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DDEC))
    else $error("result raised outside decision");

  a_fire_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(clr_fire_q))
    else $error("firing clear restarted");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("ready outside idle");

endmodule
